@@ rtl/lkv_pkg.sv @@
// shared types and constants for the lru key-value cache
package lkv_pkg;

	localparam int unsigned KEY_W = 16;
	localparam int unsigned VAL_W = 31;
	localparam int unsigned CAP_W = 5;

	// capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request type codes
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} lkv_state_t;

endpackage

@@ rtl/lkv_ifs.sv @@
// valid/ready channel interfaces for requests, results and configuration

interface lkv_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [lkv_pkg::KEY_W-1:0]  key;
	logic [lkv_pkg::VAL_W-1:0]  value;

	modport source (output valid, req_type, key, value, input ready);
	modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [lkv_pkg::VAL_W-1:0]  read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lkv_pkg::CAP_W-1:0]  capacity_in_use;

	modport source (output valid, capacity_in_use, input ready);
	modport sink   (input valid, capacity_in_use, output ready);
endinterface

@@ rtl/lru_key_value_cache.sv @@
// fully associative key-value cache with least-recently-used replacement
//
// Each request beat is a get or a put and yields exactly one result beat
// (hit flag plus the stored value on a get hit, else zero). Keys and values
// live in single-port memories that one compare unit scans one entry per
// cycle, so a request occupies the block through accept, the scan
// (registered memory reads of all ENTRIES entries, the compare of the
// last entry and a step in which the sequencer sees the compare stage
// empty) and the update cycle. The update cycle is held while the previous
// result beat has not been taken, which extends the request by that stall.
// req.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new request is taken while the previous result still
// waits. Recency ranks (0 = most recent) and valid bits are flip-flops, and
// all ranks move in parallel in the update cycle. The capacity register may
// be written at any time the block is idle; 0 acts as 1 and values above
// ENTRIES act as ENTRIES. No clearing pass is needed after reset.
module lru_key_value_cache #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lkv_req_if.sink      req,
	lkv_rsp_if.source    rsp,
	lkv_cfg_if.sink      cfg
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned AGE_W = IDX_W;
	localparam int unsigned CW    = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

	lkv_pkg::lkv_state_t state_q, state_d;

	// configuration
	logic [lkv_pkg::CAP_W-1:0] cap_q;

	// latched request
	logic                       put_q;
	logic [lkv_pkg::KEY_W-1:0]  key_q;
	logic [lkv_pkg::VAL_W-1:0]  value_q;

	// entry storage
	logic [lkv_pkg::KEY_W-1:0]  key_mem [ENTRIES];
	logic [lkv_pkg::VAL_W-1:0]  val_mem [ENTRIES];
	logic [ENTRIES-1:0]         valid_q, valid_d;
	logic [AGE_W-1:0]           age_q [ENTRIES];
	logic [AGE_W-1:0]           age_d [ENTRIES];

	// scan pipeline
	logic [CNT_W-1:0]           idx_q;
	logic                       cmp_vld_s1;
	logic [IDX_W-1:0]           cmp_idx_s1;
	logic [lkv_pkg::KEY_W-1:0]  rd_key_s1;
	logic [lkv_pkg::VAL_W-1:0]  rd_val_s1;

	// scan results
	logic                       found_q;
	logic [IDX_W-1:0]           found_idx_q;
	logic [AGE_W-1:0]           found_age_q;
	logic [lkv_pkg::VAL_W-1:0]  found_val_q;
	logic                       vict_found_q;
	logic [IDX_W-1:0]           vict_idx_q;
	logic [AGE_W-1:0]           vict_age_q;
	logic                       free_found_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [CNT_W-1:0]           occ_q;

	// result register
	logic                       out_valid_q;
	logic                       out_hit_q;
	logic [lkv_pkg::VAL_W-1:0]  out_val_q;

	// sequencer strobes
	logic                       req_acc;
	logic                       scan_rd;
	logic                       go;

	// compare stage view of the scanned entry
	logic                       cmp_v;
	logic [AGE_W-1:0]           cmp_age;

	// decision signals
	logic [CW-1:0]              cap_ext;
	logic [CW-1:0]              cap_eff;
	logic                       evict;
	logic                       insert;
	logic [IDX_W-1:0]           slot;

	assign req.ready  = (state_q == lkv_pkg::ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign req_acc    = req.valid && req.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.read_value = out_val_q;

	// next state and sequencer strobes
	always_comb begin
		state_d = state_q;
		scan_rd = 1'b0;
		go      = 1'b0;
		unique case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (req_acc) state_d = lkv_pkg::ST_SCAN;
			end
			lkv_pkg::ST_SCAN: begin
				scan_rd = (idx_q != CNT_W'(ENTRIES));
				if (!scan_rd && !cmp_vld_s1) state_d = lkv_pkg::ST_DECIDE;
			end
			lkv_pkg::ST_DECIDE: begin
				go = !out_valid_q || rsp.ready;
				if (go) state_d = lkv_pkg::ST_IDLE;
			end
			default: state_d = lkv_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.capacity_in_use;
		end
	end

	// latch the request beat
	always_ff @(posedge clk) begin
		if (req_acc) begin
			put_q   <= req.req_type;
			key_q   <= req.key;
			value_q <= req.value;
		end
	end

	// memory read port and write port
	always_ff @(posedge clk) begin
		if (scan_rd) begin
			rd_key_s1 <= key_mem[idx_q[IDX_W-1:0]];
			rd_val_s1 <= val_mem[idx_q[IDX_W-1:0]];
		end
		if (go && put_q == lkv_pkg::REQ_PUT) begin
			if (found_q) begin
				val_mem[found_idx_q] <= value_q;
			end else if (insert) begin
				key_mem[slot] <= key_q;
				val_mem[slot] <= value_q;
			end
		end
	end

	// scan counter and compare-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			if (req_acc) begin
				idx_q <= '0;
			end else if (scan_rd) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			cmp_vld_s1 <= scan_rd;
			if (scan_rd) cmp_idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	assign cmp_v   = valid_q[cmp_idx_s1];
	assign cmp_age = age_q[cmp_idx_s1];

	// compare unit: key match, oldest entry, first free slot, occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			vict_found_q <= 1'b0;
			free_found_q <= 1'b0;
			occ_q        <= '0;
		end else if (req_acc) begin
			found_q      <= 1'b0;
			vict_found_q <= 1'b0;
			free_found_q <= 1'b0;
			occ_q        <= '0;
		end else if (cmp_vld_s1) begin
			if (cmp_v) begin
				occ_q <= occ_q + CNT_W'(1);
				if (rd_key_s1 == key_q) begin
					found_q <= 1'b1;
				end
				if (!vict_found_q || cmp_age > vict_age_q) begin
					vict_found_q <= 1'b1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// compare unit payload captures
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && cmp_v) begin
			if (rd_key_s1 == key_q) begin
				found_idx_q <= cmp_idx_s1;
				found_age_q <= cmp_age;
				found_val_q <= rd_val_s1;
			end
			if (!vict_found_q || cmp_age > vict_age_q) begin
				vict_idx_q <= cmp_idx_s1;
				vict_age_q <= cmp_age;
			end
		end
		if (cmp_vld_s1 && !cmp_v && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// effective capacity and replacement decision
	always_comb begin
		cap_ext = CW'(cap_q);
		if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
		evict  = (put_q == lkv_pkg::REQ_PUT) && !found_q && vict_found_q
			&& (CW'(occ_q) >= cap_eff);
		insert = (put_q == lkv_pkg::REQ_PUT) && !found_q && (free_found_q || evict);
		if (free_found_q && (!evict || free_idx_q < vict_idx_q)) begin
			slot = free_idx_q;
		end else begin
			slot = vict_idx_q;
		end
	end

	// next valid bits and recency ranks, all entries in parallel
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_d[i] = valid_q[i];
			age_d[i]   = age_q[i];
			if (found_q) begin
				if (IDX_W'(i) == found_idx_q) begin
					age_d[i] = '0;
				end else if (valid_q[i] && age_q[i] < found_age_q) begin
					age_d[i] = AGE_W'(age_q[i] + AGE_W'(1));
				end
			end else if (put_q == lkv_pkg::REQ_PUT) begin
				if (evict && IDX_W'(i) == vict_idx_q) begin
					valid_d[i] = 1'b0;
					age_d[i]   = '0;
				end
				if (insert) begin
					if (IDX_W'(i) == slot) begin
						valid_d[i] = 1'b1;
						age_d[i]   = '0;
					end else if (valid_d[i]) begin
						age_d[i] = AGE_W'(age_d[i] + AGE_W'(1));
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
		end else if (go) begin
			valid_q <= valid_d;
			for (int i = 0; i < ENTRIES; i++) age_q[i] <= age_d[i];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_hit_q <= found_q;
			out_val_q <= (found_q && put_q == lkv_pkg::REQ_GET) ? found_val_q : '0;
		end
	end

	// a matched entry must be a live one
	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkv_pkg::ST_DECIDE && found_q) |-> valid_q[found_idx_q])
		else $error("matched entry is not valid");

	// an insert always lands in a slot that is free after eviction
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(go && insert) |-> (!valid_q[slot] || (evict && slot == vict_idx_q)))
		else $error("insert into an occupied slot");

	// a result beat appears only out of the update cycle
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lkv_pkg::ST_DECIDE))
		else $error("result beat without an update cycle");

	// occupancy is bounded by the effective capacity after every insert that evicts nothing
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(go && insert && !evict) |=> (CW'($countones(valid_q)) <= cap_eff))
		else $error("occupancy exceeds capacity");

endmodule

@@ tb/sv/lkv_tb_pkg.sv @@
// scoreboard with a cycle-free model of the lru key-value cache
package lkv_tb_pkg;

	import lkv_pkg::*;

	localparam int unsigned ENTRIES = 16;
	localparam int unsigned RANK_W = $clog2(ENTRIES);

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} cache_req_t;

	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  read_value;
	} cache_rsp_t;

	class cache_scoreboard;
		logic              slot_valid [ENTRIES];
		logic [KEY_W-1:0]  slot_key   [ENTRIES];
		logic [VAL_W-1:0]  slot_value [ENTRIES];
		logic [RANK_W-1:0] slot_rank  [ENTRIES];
		logic [CAP_W-1:0]  capacity;
		cache_rsp_t        expected_rsps[$];
		int                mismatches;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_rank[i]  = '0;
			end
			capacity   = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction

		// move slot s to rank 0, entries that were more recent age by one
		function void promote(int s);
			logic [RANK_W-1:0] old_rank;
			old_rank = slot_rank[s];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && i != s && slot_rank[i] < old_rank)
					slot_rank[i]++;
			slot_rank[s] = '0;
		endfunction

		// one access: returns the result beat and updates the table
		function cache_rsp_t predict_access(cache_req_t q);
			cache_rsp_t  r;
			int          found;
			int          victim;
			int          free_slot;
			int unsigned cap_eff;
			int unsigned occupancy;
			found = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && slot_key[i] == q.key)
					found = i;
			r.hit        = (found >= 0);
			r.read_value = '0;

			if (q.req_type == REQ_GET) begin
				if (found >= 0) begin
					r.read_value = slot_value[found];
					promote(found);
				end
				return r;
			end

			// put that hits updates in place, never evicts
			if (found >= 0) begin
				slot_value[found] = q.value;
				promote(found);
				return r;
			end

			// capacity zero acts as one, large values saturate
			cap_eff = capacity;
			if (cap_eff == 0)
				cap_eff = 1;
			if (cap_eff > ENTRIES)
				cap_eff = ENTRIES;

			occupancy = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i])
					occupancy++;

			// evict the least recent entry when full
			if (occupancy >= cap_eff) begin
				victim = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					slot_valid[victim] = 1'b0;
					slot_rank[victim]  = '0;
				end
			end

			// insert into the lowest free slot
			free_slot = -1;
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (!slot_valid[i])
					free_slot = i;
			if (free_slot < 0)
				return r;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i])
					slot_rank[i]++;
			slot_valid[free_slot] = 1'b1;
			slot_key[free_slot]   = q.key;
			slot_value[free_slot] = q.value;
			slot_rank[free_slot]  = '0;
			return r;
		endfunction

		function void note_request(cache_req_t q);
			expected_rsps.push_back(predict_access(q));
		endfunction

		function void check_result(cache_rsp_t got);
			cache_rsp_t exp_rsp;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result beat hit=%0b read_value=%h",
						$realtime, got.hit, got.read_value);
				return;
			end
			exp_rsp = expected_rsps.pop_front();
			if (exp_rsp.hit !== got.hit || exp_rsp.read_value !== got.read_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch, expected hit=%0b read_value=%h,",
						$realtime, exp_rsp.hit, exp_rsp.read_value,
						" got hit=%0b read_value=%h", got.hit, got.read_value);
			end
		endfunction
	endclass

endpackage

@@ tb/sv/lru_key_value_cache_test.sv @@
// top-level testbench for the lru key-value cache
module lru_key_value_cache_test;

	timeunit 1ns;
	timeprecision 1ps;

	import lkv_pkg::*;
	import lkv_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 48;
	localparam int POOL_SIZE    = 24;

	logic clk;
	logic arst_n;

	lkv_req_if req_ch();
	lkv_rsp_if rsp_ch();
	lkv_cfg_if cfg_ch();

	lru_key_value_cache #(
		.ENTRIES (ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	cache_scoreboard sb;
	int              src_idle_pct;
	int              sink_idle_pct;
	int              cycle_count;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// one request beat, with random idle cycles ahead of it
	task automatic send_req(input logic req_type, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] value);
		cache_req_t q;
		q.req_type = req_type;
		q.key      = key;
		q.value    = value;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= q.req_type;
		req_ch.key      <= q.key;
		req_ch.value    <= q.value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(q);
	endtask

	// capacity write, only once every result has drained
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.capacity_in_use <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_capacity(c);
	endtask

	// result receiver with random stalls
	initial begin
		cache_rsp_t got;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.hit        = rsp_ch.hit;
				got.read_value = rsp_ch.read_value;
				sb.check_result(got);
			end
		end
	end

	// stimulus
	initial begin
		logic [CAP_W-1:0] phase_caps [9];
		int unsigned      cap_eff;
		int unsigned      key_span;
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;

		sb = new();
		phase_caps = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd16, 5'd5, 5'd12, 5'd2};
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);

		src_idle_pct  = 38;
		sink_idle_pct = 88;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.req_type        <= REQ_GET;
		req_ch.key             <= '0;
		req_ch.value           <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.capacity_in_use <= CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, extremes, update in place, fill and evict
		send_req(REQ_GET, '0, '1);
		send_req(REQ_PUT, '0, '0);
		send_req(REQ_PUT, '1, '1);
		send_req(REQ_GET, '1, VAL_W'($urandom));
		send_req(REQ_GET, '0, '0);
		send_req(REQ_PUT, '0, 31'h5555_5555);
		send_req(REQ_GET, '0, '0);
		for (int k = 0; k < ENTRIES - 2; k++)
			send_req(REQ_PUT, KEY_W'(16'h0100 + k), VAL_W'($urandom));
		send_req(REQ_PUT, 16'h0200, VAL_W'($urandom));
		send_req(REQ_GET, '1, '0);
		send_req(REQ_GET, 16'h0100, '0);

		// random phases, each under its own capacity setting
		for (int p = 0; p < 9; p++) begin
			write_capacity(phase_caps[p]);
			if (p < 3) begin
				src_idle_pct  = 38;
				sink_idle_pct = 88;
			end else if (p < 6) begin
				src_idle_pct  = 88;
				sink_idle_pct = 38;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			cap_eff = (phase_caps[p] == 0) ? 1 :
				(phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
			key_span = (cap_eff + 3 < POOL_SIZE) ? cap_eff + 3 : POOL_SIZE - 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				req_type = $urandom_range(1) ? REQ_PUT : REQ_GET;
				// mostly a small key set so hits and evictions are common
				if ($urandom_range(9) == 0)
					key = KEY_W'($urandom);
				else
					key = key_pool[$urandom_range(key_span)];
				case ($urandom_range(15))
					0:       value = '0;
					1:       value = '1;
					default: value = VAL_W'($urandom);
				endcase
				send_req(req_type, key, value);
			end
		end

		// drain and settle
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
